// ----- hdl/gps_pkg.sv -----
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types, constants and saturation helpers for the gravity step block.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int NUM_SOURCES_DEF = 2;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_SOURCES     = 2;

  localparam int WORD_W    = 32;
  localparam int STR_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Register map: each source owns three consecutive indexes.
  localparam int REGS_PER_SOURCE = 3;
  localparam int REG_OFS_X       = 0;
  localparam int REG_OFS_Y       = 1;
  localparam int REG_OFS_STR     = 2;

  // Source positions after reset, in whole units, and strengths.
  localparam int SRC_X_WHOLE   [MAX_SOURCES] = '{500, 1200};
  localparam int SRC_Y_WHOLE   [MAX_SOURCES] = '{500, 500};
  localparam int SRC_STR_RESET [MAX_SOURCES] = '{7000, 7000};

  // The square root and the strength division both take one bit per cell.
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  // Unit vector quotient holds up to FRAC_BITS + 1 bits; sized for the widest case.
  localparam int UQ_W       = 25;
  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [WORD_W-1:0] particle_x;
    logic signed [WORD_W-1:0] particle_y;
    logic signed [WORD_W-1:0] velocity_x;
    logic signed [WORD_W-1:0] velocity_y;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_x;
    logic signed [WORD_W-1:0] new_y;
    logic signed [WORD_W-1:0] new_velocity_x;
    logic signed [WORD_W-1:0] new_velocity_y;
    logic                     clipped;
  } out_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] px;
    logic signed [WORD_W-1:0] py;
    logic signed [WORD_W-1:0] vx;
    logic signed [WORD_W-1:0] vy;
    logic                     clip;
  } particle_t;

  // Data handed along the square root / strength division row.
  typedef struct packed {
    particle_t                st;
    logic signed [WORD_W-1:0] dx;
    logic signed [WORD_W-1:0] dy;
    logic                     zero;
    logic                     satmag;
    logic [STR_W-1:0]         str;
    logic [63:0]              n;
    logic [31:0]              root;
    logic [33:0]              srem;
    logic [63:0]              den;
    logic [63:0]              drem;
    logic [31:0]              q;
  } rd_t;

  // Data handed along the unit vector division row.
  typedef struct packed {
    particle_t                st;
    logic signed [WORD_W-1:0] dx;
    logic signed [WORD_W-1:0] dy;
    logic                     zero;
    logic [30:0]              mag;
    logic [31:0]              span;
    logic [31:0]              mx;
    logic [31:0]              my;
    logic [31:0]              remx;
    logic [31:0]              remy;
    logic [UQ_W-1:0]          ux;
    logic [UQ_W-1:0]          uy;
  } ucell_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W:0] v);
    if (v[WORD_W] != v[WORD_W-1]) begin
      return v[WORD_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[WORD_W-1:0];
  endfunction

  function automatic logic ovf_word(input logic signed [WORD_W:0] v);
    return v[WORD_W] ^ v[WORD_W-1];
  endfunction

  function automatic logic signed [WORD_W-1:0] reset_pos(input int whole, input int frac);
    longint v;
    v = longint'(whole) <<< frac;
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    return v[WORD_W-1:0];
  endfunction

endpackage

// ----- hdl/gps_if.sv -----
// ----------------------------------------------------------------------------
// gps_in_if / gps_out_if
// Valid/ready channels carrying particle words into and out of the block.
// ----------------------------------------------------------------------------
interface gps_in_if;
  logic               valid;
  logic               ready;
  gps_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gps_out_if;
  logic               valid;
  logic               ready;
  gps_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gravity_particle_step.sv -----
// ----------------------------------------------------------------------------
// gravity_particle_step
// One semi-implicit Euler frame of a particle under point gravity sources.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          contents
//  in_ch     in    valid / ready      particle position and velocity word
//  out_ch    out   valid / ready      updated position, velocity, clipped flag
//  cfg_*     in    cfg_we (no wait)   source positions and strengths
//
//  A new word is taken every cycle while the skid register is empty. Each source
//  registers offset, square, sum and setup stages, the root/division and unit
//  cell rows, and acceleration, velocity and position stages, ahead of the output register.
//  Reset is synchronous; the sources return to their default positions.
//  A skid register behind the output keeps ready registered: the pipeline
//  freezes only when both the output and skid registers are full.
// ----------------------------------------------------------------------------
module gravity_particle_step #(
  parameter int NUM_SOURCES = gps_pkg::NUM_SOURCES_DEF,
  parameter int FRAC_BITS   = gps_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gps_in_if.sink                          in_ch,
  gps_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gps_pkg::WORD_W-1:0]      cfg_wdata
);

  logic signed [31:0]  src_x_r   [NUM_SOURCES];
  logic signed [31:0]  src_y_r   [NUM_SOURCES];
  logic [15:0]         src_str_r [NUM_SOURCES];

  logic                adv;
  logic                stage_v  [NUM_SOURCES+1];
  gps_pkg::particle_t  stage_st [NUM_SOURCES+1];

  logic                out_v_r, skid_v_r;
  gps_pkg::out_word_t  out_d_r, skid_d_r, res_d;
  logic                res_v;

  assign adv         = ~skid_v_r;
  assign in_ch.ready = adv & rst_n;

  assign stage_v[0]          = in_ch.valid & in_ch.ready;
  assign stage_st[0].px      = in_ch.data.particle_x;
  assign stage_st[0].py      = in_ch.data.particle_y;
  assign stage_st[0].vx      = in_ch.data.velocity_x;
  assign stage_st[0].vy      = in_ch.data.velocity_y;
  assign stage_st[0].clip    = 1'b0;

  for (genvar s = 0; s < NUM_SOURCES; s++) begin : g_src
    localparam logic [gps_pkg::CFG_IDX_W-1:0] IDX_X =
      gps_pkg::CFG_IDX_W'(gps_pkg::REGS_PER_SOURCE * s + gps_pkg::REG_OFS_X);
    localparam logic [gps_pkg::CFG_IDX_W-1:0] IDX_Y =
      gps_pkg::CFG_IDX_W'(gps_pkg::REGS_PER_SOURCE * s + gps_pkg::REG_OFS_Y);
    localparam logic [gps_pkg::CFG_IDX_W-1:0] IDX_STR =
      gps_pkg::CFG_IDX_W'(gps_pkg::REGS_PER_SOURCE * s + gps_pkg::REG_OFS_STR);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        src_x_r[s]   <= gps_pkg::reset_pos(gps_pkg::SRC_X_WHOLE[s], FRAC_BITS);
        src_y_r[s]   <= gps_pkg::reset_pos(gps_pkg::SRC_Y_WHOLE[s], FRAC_BITS);
        src_str_r[s] <= 16'(gps_pkg::SRC_STR_RESET[s]);
      end else if (cfg_we) begin
        if (cfg_index == IDX_X) begin
          src_x_r[s] <= cfg_wdata;
        end
        if (cfg_index == IDX_Y) begin
          src_y_r[s] <= cfg_wdata;
        end
        if (cfg_index == IDX_STR) begin
          src_str_r[s] <= cfg_wdata[15:0];
        end
      end
    end

    gps_source_unit #(
      .FRAC_BITS (FRAC_BITS)
    ) u_source (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_v    (stage_v[s]),
      .in_st   (stage_st[s]),
      .src_x   (src_x_r[s]),
      .src_y   (src_y_r[s]),
      .src_str (src_str_r[s]),
      .out_v   (stage_v[s+1]),
      .out_st  (stage_st[s+1])
    );
  end

  assign res_v                = stage_v[NUM_SOURCES] & adv;
  assign res_d.new_x          = stage_st[NUM_SOURCES].px;
  assign res_d.new_y          = stage_st[NUM_SOURCES].py;
  assign res_d.new_velocity_x = stage_st[NUM_SOURCES].vx;
  assign res_d.new_velocity_y = stage_st[NUM_SOURCES].vy;
  assign res_d.clipped        = stage_st[NUM_SOURCES].clip;

  // The skid register catches the word that arrives while the output is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= res_v;
        out_d_r  <= res_d;
      end
    end else if (res_v) begin
      skid_v_r <= 1'b1;
      skid_d_r <= res_d;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

endmodule

// ----- hdl/gps_root_div_cell.sv -----
// ----------------------------------------------------------------------------
// gps_root_div_cell
// One bit of the distance square root and one bit of strength / r2.
// ----------------------------------------------------------------------------
module gps_root_div_cell #(
  parameter int STEP      = 0,
  parameter int FRAC_BITS = gps_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  gps_pkg::rd_t  in_c,
  output logic          out_v,
  output gps_pkg::rd_t  out_c
);

  localparam int K3      = 3 * FRAC_BITS;
  localparam int BIT_POS = gps_pkg::DIV_STEPS - 1 - STEP;
  localparam bit BRINGS  = (BIT_POS >= K3);
  localparam int STR_BIT = BRINGS ? (BIT_POS - K3) : 0;

  logic          out_v_r;
  gps_pkg::rd_t  out_c_r;
  gps_pkg::rd_t  c_nxt;
  logic [35:0]   srem_sh;
  logic [35:0]   trial;
  logic [64:0]   drem_sh;
  logic          bit_in;

  always_comb begin
    c_nxt   = in_c;
    // Root: bring down the next two radicand bits and try root*4+1.
    srem_sh = {in_c.srem, in_c.n[63:62]};
    trial   = {2'b00, in_c.root, 2'b01};
    if (srem_sh >= trial) begin
      c_nxt.srem = 34'(srem_sh - trial);
      c_nxt.root = {in_c.root[30:0], 1'b1};
    end else begin
      c_nxt.srem = srem_sh[33:0];
      c_nxt.root = {in_c.root[30:0], 1'b0};
    end
    c_nxt.n = {in_c.n[61:0], 2'b00};
    // Division: the dividend is the strength shifted up by three fraction widths.
    bit_in  = BRINGS ? in_c.str[STR_BIT] : 1'b0;
    drem_sh = {in_c.drem, bit_in};
    if (drem_sh >= {1'b0, in_c.den}) begin
      c_nxt.drem = 64'(drem_sh - {1'b0, in_c.den});
      c_nxt.q    = {in_c.q[30:0], 1'b1};
    end else begin
      c_nxt.drem = drem_sh[63:0];
      c_nxt.q    = {in_c.q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
      out_c_r <= c_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_c = out_c_r;

endmodule

// ----- hdl/gps_unit_cell.sv -----
// ----------------------------------------------------------------------------
// gps_unit_cell
// One quotient bit of |dx| / dist and |dy| / dist for the unit direction.
// ----------------------------------------------------------------------------
module gps_unit_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  gps_pkg::ucell_t in_c,
  output logic            out_v,
  output gps_pkg::ucell_t out_c
);

  logic            out_v_r;
  gps_pkg::ucell_t out_c_r;
  gps_pkg::ucell_t c_nxt;
  logic [32:0]     xs;
  logic [32:0]     ys;

  always_comb begin
    c_nxt = in_c;
    // Only the first bit brought down, the low bit of |dx| or |dy|, can be nonzero.
    xs = {in_c.remx, (STEP == 0) ? in_c.mx[0] : 1'b0};
    ys = {in_c.remy, (STEP == 0) ? in_c.my[0] : 1'b0};
    if (xs >= {1'b0, in_c.span}) begin
      c_nxt.remx = 32'(xs - {1'b0, in_c.span});
      c_nxt.ux   = {in_c.ux[gps_pkg::UQ_W-2:0], 1'b1};
    end else begin
      c_nxt.remx = xs[31:0];
      c_nxt.ux   = {in_c.ux[gps_pkg::UQ_W-2:0], 1'b0};
    end
    if (ys >= {1'b0, in_c.span}) begin
      c_nxt.remy = 32'(ys - {1'b0, in_c.span});
      c_nxt.uy   = {in_c.uy[gps_pkg::UQ_W-2:0], 1'b1};
    end else begin
      c_nxt.remy = ys[31:0];
      c_nxt.uy   = {in_c.uy[gps_pkg::UQ_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
      out_c_r <= c_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_c = out_c_r;

endmodule

// ----- hdl/gps_source_unit.sv -----
// ----------------------------------------------------------------------------
// gps_source_unit
// Applies one gravity source: offset, r2, cell rows, acceleration, update.
// ----------------------------------------------------------------------------
module gps_source_unit #(
  parameter int FRAC_BITS = gps_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  gps_pkg::particle_t       in_st,
  input  logic signed [31:0]       src_x,
  input  logic signed [31:0]       src_y,
  input  logic [15:0]              src_str,
  output logic                     out_v,
  output gps_pkg::particle_t       out_st
);

  localparam int K3      = 3 * FRAC_BITS;
  localparam int U_STEPS = FRAC_BITS + 1;

  // Offset stage.
  logic signed [32:0]  dx_full, dy_full;
  gps_pkg::particle_t  s1_st_nxt;
  logic                s1_v_r;
  gps_pkg::particle_t  s1_st_r;
  logic signed [31:0]  s1_dx_r, s1_dy_r;

  assign dx_full = 33'(src_x) - 33'(in_st.px);
  assign dy_full = 33'(src_y) - 33'(in_st.py);

  always_comb begin
    s1_st_nxt      = in_st;
    s1_st_nxt.clip = in_st.clip | gps_pkg::ovf_word(dx_full) | gps_pkg::ovf_word(dy_full);
  end

  // Square stage.
  logic [31:0]         mx, my;
  logic                s2_v_r;
  gps_pkg::particle_t  s2_st_r;
  logic signed [31:0]  s2_dx_r, s2_dy_r;
  logic [63:0]         s2_sqx_r, s2_sqy_r;

  assign mx = s1_dx_r[31] ? (~s1_dx_r + 32'd1) : s1_dx_r;
  assign my = s1_dy_r[31] ? (~s1_dy_r + 32'd1) : s1_dy_r;

  // Sum stage.
  logic [63:0]         r2_nxt;
  logic                s3_v_r;
  gps_pkg::particle_t  s3_st_r;
  logic signed [31:0]  s3_dx_r, s3_dy_r;
  logic [63:0]         s3_r2_r;
  logic                s3_zero_r;

  assign r2_nxt = s2_sqx_r + s2_sqy_r;

  // Row setup: saturation test of strength / r2 and the first partial remainder.
  logic [95:0]         num_full;
  logic                satmag;
  gps_pkg::rd_t        rd_nxt;
  logic                s4_v_r;
  gps_pkg::rd_t        s4_c_r;

  assign num_full = 96'(src_str) << K3;
  // The quotient exceeds 31 bits exactly when the dividend reaches r2 * 2^31.
  assign satmag   = ~s3_zero_r & (num_full >= 96'({s3_r2_r, 31'd0}));

  always_comb begin
    rd_nxt         = '0;
    rd_nxt.st      = s3_st_r;
    rd_nxt.st.clip = s3_st_r.clip | s3_zero_r | satmag;
    rd_nxt.dx      = s3_dx_r;
    rd_nxt.dy      = s3_dy_r;
    rd_nxt.zero    = s3_zero_r;
    rd_nxt.satmag  = satmag;
    rd_nxt.str     = src_str;
    rd_nxt.n       = s3_r2_r;
    rd_nxt.den     = s3_r2_r;
    rd_nxt.drem    = num_full[95:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r    <= in_v;
      s1_st_r   <= s1_st_nxt;
      s1_dx_r   <= gps_pkg::sat_word(dx_full);
      s1_dy_r   <= gps_pkg::sat_word(dy_full);
      s2_v_r    <= s1_v_r;
      s2_st_r   <= s1_st_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_sqx_r  <= mx * mx;
      s2_sqy_r  <= my * my;
      s3_v_r    <= s2_v_r;
      s3_st_r   <= s2_st_r;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
      s3_r2_r   <= r2_nxt;
      s3_zero_r <= (r2_nxt == 64'd0);
      s4_v_r    <= s3_v_r;
      s4_c_r    <= rd_nxt;
    end
  end

  // Square root and strength division row.
  logic          rd_v [gps_pkg::ROOT_STEPS+1];
  gps_pkg::rd_t  rd_c [gps_pkg::ROOT_STEPS+1];

  assign rd_v[0] = s4_v_r;
  assign rd_c[0] = s4_c_r;

  for (genvar j = 0; j < gps_pkg::ROOT_STEPS; j++) begin : g_rd
    gps_root_div_cell #(
      .STEP      (j),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (rd_v[j]),
      .in_c  (rd_c[j]),
      .out_v (rd_v[j+1]),
      .out_c (rd_c[j+1])
    );
  end

  // Unit direction row, seeded from the finished root and quotient.
  gps_pkg::rd_t     rd_end;
  gps_pkg::ucell_t  u_seed;
  logic [31:0]      ex, ey;

  assign rd_end = rd_c[gps_pkg::ROOT_STEPS];
  assign ex = rd_end.dx[31] ? (~rd_end.dx + 32'd1) : rd_end.dx;
  assign ey = rd_end.dy[31] ? (~rd_end.dy + 32'd1) : rd_end.dy;

  always_comb begin
    u_seed      = '0;
    u_seed.st   = rd_end.st;
    u_seed.dx   = rd_end.dx;
    u_seed.dy   = rd_end.dy;
    u_seed.zero = rd_end.zero;
    u_seed.mag  = rd_end.satmag ? gps_pkg::MAG_MAX : rd_end.q[30:0];
    u_seed.span = rd_end.root;
    u_seed.mx   = ex;
    u_seed.my   = ey;
    u_seed.remx = {1'b0, ex[31:1]};
    u_seed.remy = {1'b0, ey[31:1]};
  end

  logic             u_v [U_STEPS+1];
  gps_pkg::ucell_t  u_c [U_STEPS+1];

  assign u_v[0] = rd_v[gps_pkg::ROOT_STEPS];
  assign u_c[0] = u_seed;

  for (genvar j = 0; j < U_STEPS; j++) begin : g_unit
    gps_unit_cell #(
      .STEP (j)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (u_v[j]),
      .in_c  (u_c[j]),
      .out_v (u_v[j+1]),
      .out_c (u_c[j+1])
    );
  end

  // Acceleration magnitude stage.
  gps_pkg::ucell_t     u_end;
  logic [55:0]         prod_x, prod_y;
  logic                s6_v_r;
  gps_pkg::particle_t  s6_st_r;
  logic                s6_negx_r, s6_negy_r, s6_zero_r;
  logic [30:0]         s6_ax_r, s6_ay_r;

  assign u_end  = u_c[U_STEPS];
  assign prod_x = u_end.mag * u_end.ux;
  assign prod_y = u_end.mag * u_end.uy;

  // Velocity stage.
  logic signed [32:0]  ax, ay, vx_sum, vy_sum;
  gps_pkg::particle_t  s7_nxt;
  logic                s7_v_r;
  gps_pkg::particle_t  s7_st_r;

  always_comb begin
    ax = s6_negx_r ? -$signed({2'b00, s6_ax_r}) : $signed({2'b00, s6_ax_r});
    ay = s6_negy_r ? -$signed({2'b00, s6_ay_r}) : $signed({2'b00, s6_ay_r});
    if (s6_zero_r) begin
      ax = '0;
      ay = '0;
    end
    vx_sum      = 33'(s6_st_r.vx) + ax;
    vy_sum      = 33'(s6_st_r.vy) + ay;
    s7_nxt      = s6_st_r;
    s7_nxt.vx   = gps_pkg::sat_word(vx_sum);
    s7_nxt.vy   = gps_pkg::sat_word(vy_sum);
    s7_nxt.clip = s6_st_r.clip | gps_pkg::ovf_word(vx_sum) | gps_pkg::ovf_word(vy_sum);
  end

  // Position stage.
  logic signed [32:0]  px_sum, py_sum;
  gps_pkg::particle_t  s8_nxt;
  logic                s8_v_r;
  gps_pkg::particle_t  s8_st_r;

  always_comb begin
    px_sum      = 33'(s7_st_r.px) + 33'(s7_st_r.vx);
    py_sum      = 33'(s7_st_r.py) + 33'(s7_st_r.vy);
    s8_nxt      = s7_st_r;
    s8_nxt.px   = gps_pkg::sat_word(px_sum);
    s8_nxt.py   = gps_pkg::sat_word(py_sum);
    s8_nxt.clip = s7_st_r.clip | gps_pkg::ovf_word(px_sum) | gps_pkg::ovf_word(py_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r    <= u_v[U_STEPS];
      s6_st_r   <= u_end.st;
      s6_negx_r <= u_end.dx[31];
      s6_negy_r <= u_end.dy[31];
      s6_zero_r <= u_end.zero;
      s6_ax_r   <= 31'(prod_x >> FRAC_BITS);
      s6_ay_r   <= 31'(prod_y >> FRAC_BITS);
      s7_v_r    <= s6_v_r;
      s7_st_r   <= s7_nxt;
      s8_v_r    <= s7_v_r;
      s8_st_r   <= s8_nxt;
    end
  end

  assign out_v  = s8_v_r;
  assign out_st = s8_st_r;

endmodule
